// File: rtl/tdf_pkg.sv
// Package for the trial-division factorizer: result field widths, status codes,
// result cap and the sequencer state type. Depends on nothing.
package tdf_pkg;

   localparam int FactorWidth = 31;
   localparam int MaxResults  = 31;
   localparam int CountWidth  = 5;

   typedef enum logic [1:0] {
      STATUS_LIST  = 2'd0,
      STATUS_PRIME = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_DECIDE
   } state_type;

endpackage

// File: rtl/trial_division_factorizer_top.sv
// Trial-division factorizer: a bit-serial restoring divider shared by every
// trial, under a four-state sequencer. Depends on tdf_pkg.
//
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  req_value (signed, VALUE_WIDTH)
// rsp      out        rsp_valid/rsp_stall  rsp_factor[30:0], rsp_status[1:0], rsp_last
//
// Each trial divisor takes VALUE_WIDTH-1 divider steps in ST_DIV and one decide
// step in ST_DECIDE. After the start step, an item runs one such trial for every
// divisor tried and one more for every factor found.
// req_stall is high from the accepted beat until the last result is loaded.
// A stalled result holds the sequencer only at the cycle that emits the next one.
// Reset clears the sequencer and the result valid; nothing else needs it.
module trial_division_factorizer_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tdf_pkg::FactorWidth-1:0] rsp_factor,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last
);

   localparam int NW  = VALUE_WIDTH - 1;
   localparam int FW  = tdf_pkg::FactorWidth;
   localparam int CW  = tdf_pkg::CountWidth;
   localparam int SCW = $clog2(NW);

   tdf_pkg::state_type  state_ff, state_in;
   logic [NW-1:0]       rem_ff, rem_in;
   logic [NW-1:0]       div_ff, div_in;
   logic [NW-1:0]       part_ff, part_in;
   logic [NW-1:0]       quo_ff, quo_in;
   logic [SCW-1:0]      step_ff, step_in;
   logic                found_ff, found_in;
   logic                err_ff, err_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]       rsp_factor_ff, rsp_factor_in;
   tdf_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                can_put;
   logic [NW:0]         shifted;
   logic [NW:0]         diff;
   logic                last_factor;
   logic [NW+FW-1:0]    rem_wide;
   logic [NW+FW-1:0]    div_wide;

   assign can_put     = !rsp_valid_ff || !rsp_stall;
   assign shifted     = {part_ff, quo_ff[NW-1]};
   assign diff        = shifted - {1'b0, div_ff};
   assign last_factor = (quo_ff <= NW'(1)) ||
                        (count_ff == CW'(tdf_pkg::MaxResults - 1));
   assign rem_wide    = {{FW{1'b0}}, rem_ff};
   assign div_wide    = {{FW{1'b0}}, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      part_ff       <= part_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      found_ff      <= found_in;
      err_ff        <= err_in;
      count_ff      <= count_in;
      rsp_factor_ff <= rsp_factor_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      part_in       = part_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      err_in        = err_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_factor_in = rsp_factor_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         tdf_pkg::ST_IDLE: begin
            if (req_valid) begin
               rem_in   = req_value[NW-1:0];
               err_in   = (req_value == '0) || req_value[VALUE_WIDTH-1];
               state_in = tdf_pkg::ST_START;
            end
         end
         tdf_pkg::ST_START: begin
            if (err_ff || rem_ff <= NW'(1)) begin
               // error marker, or the value one giving the list [1]
               if (can_put) begin
                  rsp_valid_in  = 1'b1;
                  rsp_factor_in = err_ff ? '0 : FW'(1);
                  rsp_status_in = err_ff ? tdf_pkg::STATUS_ERROR : tdf_pkg::STATUS_LIST;
                  rsp_last_in   = 1'b1;
                  state_in      = tdf_pkg::ST_IDLE;
               end
            end else begin
               div_in   = NW'(2);
               found_in = 1'b0;
               count_in = '0;
               part_in  = '0;
               quo_in   = rem_ff;
               step_in  = '0;
               state_in = tdf_pkg::ST_DIV;
            end
         end
         tdf_pkg::ST_DIV: begin
            // one restoring step: quotient bit shifts in at the bottom of quo
            if (!diff[NW]) begin
               part_in = diff[NW-1:0];
               quo_in  = {quo_ff[NW-2:0], 1'b1};
            end else begin
               part_in = shifted[NW-1:0];
               quo_in  = {quo_ff[NW-2:0], 1'b0};
            end
            step_in = step_ff + SCW'(1);
            if (step_ff == SCW'(NW - 1)) begin
               state_in = tdf_pkg::ST_DECIDE;
            end
         end
         tdf_pkg::ST_DECIDE: begin
            if (div_ff > quo_ff) begin
               // divisor passed the square root: prime, or the last cofactor
               if (can_put) begin
                  rsp_valid_in  = 1'b1;
                  rsp_factor_in = found_ff ? rem_wide[FW-1:0] : '0;
                  rsp_status_in = found_ff ? tdf_pkg::STATUS_LIST : tdf_pkg::STATUS_PRIME;
                  rsp_last_in   = 1'b1;
                  state_in      = tdf_pkg::ST_IDLE;
               end
            end else if (part_ff == '0) begin
               if (can_put) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = tdf_pkg::STATUS_LIST;
                  if (!found_ff) begin
                     // first factor: lead the list with 1, stay to emit the factor
                     rsp_factor_in = FW'(1);
                     rsp_last_in   = 1'b0;
                     found_in      = 1'b1;
                     count_in      = CW'(1);
                  end else begin
                     rsp_factor_in = div_wide[FW-1:0];
                     rsp_last_in   = last_factor;
                     count_in      = count_ff + CW'(1);
                     rem_in        = quo_ff;
                     part_in       = '0;
                     step_in       = '0;
                     state_in      = last_factor ? tdf_pkg::ST_IDLE : tdf_pkg::ST_DIV;
                  end
               end
            end else begin
               // advance to the next divisor, dividend is the unchanged cofactor
               div_in   = div_ff + NW'(1);
               part_in  = '0;
               quo_in   = rem_ff;
               step_in  = '0;
               state_in = tdf_pkg::ST_DIV;
            end
         end
         default: begin
            state_in = tdf_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall  = (state_ff != tdf_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_factor = rsp_factor_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// File: bench/tb_trial_division_factorizer_top.sv
`timescale 1ns / 100ps
// Testbench for trial_division_factorizer_top: directed and random values, with
// the factor list predicted per accepted beat. Depends on tdf_pkg and the RTL.
module tb_trial_division_factorizer_top;

   localparam int IdleLimit   = 250000;
   localparam int TailCycles  = 200;
   localparam int HoldCycles  = 2500;
   localparam int FW          = tdf_pkg::FactorWidth;

   typedef struct packed {
      logic [FW-1:0]       factor;
      tdf_pkg::status_type status;
      logic                last;
   } factor_beat_type;

   logic                    clock;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [31:0]      req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [FW-1:0]           rsp_factor;
   logic [1:0]              rsp_status;
   logic                    rsp_last;

   factor_beat_type pending_factors [$];
   int              error_count      = 0;
   int              send_idle_pct    = 0;
   int              recv_idle_pct    = 0;
   int              hold_request_len = 0;
   int              hold_left        = 0;
   int              quiet_cycles     = 0;

   trial_division_factorizer_top #(
      .VALUE_WIDTH(32)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_factor (rsp_factor),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic bit is_trial_prime(input longint unsigned n);
      longint unsigned d;
      if (n < 64'd2) return 1'b0;
      for (d = 64'd2; d <= n / d; d++) begin
         if (n % d == 64'd0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Queue the result beats that one accepted value must produce.
   function automatic void predict_factor_beats(input logic signed [31:0] value);
      longint unsigned n;
      longint unsigned rem;
      longint unsigned d;
      factor_beat_type run [$];
      factor_beat_type b;
      n = {32'b0, value};
      b.factor = '0;
      b.last   = 1'b1;
      if (n == 64'd0 || value[31]) begin
         b.status = tdf_pkg::STATUS_ERROR;
         pending_factors.push_back(b);
         return;
      end
      if (is_trial_prime(n)) begin
         b.status = tdf_pkg::STATUS_PRIME;
         pending_factors.push_back(b);
         return;
      end
      b.status = tdf_pkg::STATUS_LIST;
      b.last   = 1'b0;
      b.factor = FW'(1);
      run.push_back(b);
      rem = n;
      d   = 64'd2;
      while (run.size() < tdf_pkg::MaxResults && rem > 64'd1) begin
         if (d > rem / d) begin
            b.factor = rem[FW-1:0];
            run.push_back(b);
            rem = 64'd1;
         end else if (rem % d == 64'd0) begin
            b.factor = d[FW-1:0];
            run.push_back(b);
            rem = rem / d;
         end else begin
            d++;
         end
      end
      run[run.size()-1].last = 1'b1;
      foreach (run[i]) pending_factors.push_back(run[i]);
   endfunction

   // Offer one value; return at the edge that accepts it.
   task automatic send_value(input logic signed [31:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_factor_beats(value);
   endtask

   // Drop valid and hold until every predicted beat has arrived.
   task automatic wait_for_factors();
      req_valid <= 1'b0;
      while (pending_factors.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_value();
      int              sel;
      int              lim_bits;
      longint unsigned v;
      longint unsigned lim;
      longint unsigned p;
      sel = $urandom_range(0, 99);
      if (sel < 2) return '0;
      if (sel < 12) return {1'b1, 31'($urandom)};
      if (sel < 25) return $urandom_range(1, 3000);
      // smooth product keeps the number of trial divisors small
      v = (sel < 90) ? 64'($urandom_range(1, 4000)) : 64'($urandom_range(1, 60000));
      lim_bits = $urandom_range(12, 31);
      lim = (64'd1 << lim_bits) - 64'd1;
      for (int i = 0; i < 40; i++) begin
         p = 64'($urandom_range(2, 127));
         if (v * p > lim) break;
         v = v * p;
      end
      return v[31:0];
   endfunction

   task automatic test_directed_values();
      logic [31:0] vals [] = '{
         32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0,
         32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd49, 32'd121, 32'd97,
         32'd8191, 32'd1001, 32'd510510, 32'd1048573, 32'h4000_0000,
         32'h6000_0000, 32'h7FFF_FFFE, 32'h5555_5555, 32'h4000_0001
      };
      send_idle_pct = 0;
      recv_idle_pct = 0;
      foreach (vals[i]) send_value(vals[i]);
      wait_for_factors();
   endtask

   task automatic test_random_factoring(input int count, input int snd_pct,
                                        input int rcv_pct);
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      repeat (count) send_value(random_value());
      wait_for_factors();
   endtask

   task automatic test_output_backpressure();
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      hold_request_len = HoldCycles;
      send_value(32'd360);
      send_value(32'd1001);
      send_value(32'd2310);
      send_value(32'hFFFF_FFF0);
      send_value(32'd1024);
      send_value(32'd97);
      wait_for_factors();
   endtask

   // Receiver: random stall, or a long counted hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_request_len > 0) begin
         hold_left        = hold_request_len;
         hold_request_len = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      factor_beat_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_factors.size() == 0) begin
            report_mismatch($sformatf("unexpected beat factor=%0d status=%0d last=%0d",
                                      rsp_factor, rsp_status, rsp_last));
         end else begin
            exp = pending_factors.pop_front();
            if (rsp_factor !== exp.factor)
               report_mismatch($sformatf("factor %0d, predicted %0d",
                                         rsp_factor, exp.factor));
            if (rsp_status !== exp.status)
               report_mismatch($sformatf("status %0d, predicted %0d",
                                         rsp_status, exp.status));
            if (rsp_last !== exp.last)
               report_mismatch($sformatf("last %0d, predicted %0d (factor %0d)",
                                         rsp_last, exp.last, exp.factor));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IdleLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_values();
      test_random_factoring(70, 26, 52);
      test_output_backpressure();
      test_random_factoring(70, 52, 26);
      test_random_factoring(60, 0, 0);
      wait_for_factors();
      repeat (TailCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: trial_division_factorizer_top.f
rtl/tdf_pkg.sv
rtl/trial_division_factorizer_top.sv
bench/tb_trial_division_factorizer_top.sv
